// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int POS_W       = 16;
    localparam int CFG_W       = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_FRONT_WAIT,
        ST_EVICT,
        ST_BACK_WAIT,
        ST_APPEND
    } t_state;

    typedef struct packed {
        logic not_empty;
        logic restart;
    } t_front_stat;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_max.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-----------------------------
// input     | push / full                 | i_sample, i_restart
// result    | empty / pop                 | o_window_max
// config    | i_cfg_valid / o_cfg_ready   | i_cfg_window_size
//
// Per sample: drop expired entries at the front, then entries not above the
// sample at the back, then append it; each drop but a front drop that empties
// the deque waits on a read, set by the single read port of the deque RAM.
// A 4-entry input queue keeps taking samples meanwhile.
// Reset is synchronous, active low; window size returns to 1, deque empty.
// The back end stalls only while a new result waits on an untaken one.

module sliding_window_max
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_restart,
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_max,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [CFG_W-1:0]               i_cfg_window_size
);

    logic [CFG_W-1:0]               r_window_size;
    t_front_stat                    stat;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;
    logic                           q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    swm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_sample  (i_sample),
        .i_restart (i_restart),
        .o_stat    (stat),
        .o_sample  (q_sample),
        .i_q_pop   (q_pop)
    );

    swm_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_size (r_window_size),
        .i_stat        (stat),
        .i_sample      (q_sample),
        .o_q_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .o_window_max  (o_window_max)
    );

endmodule

`default_nettype wire

// ===== rtl/swm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/swm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_front
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_restart,
    output t_front_stat                         o_stat,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample,
    input  wire logic                           i_q_pop
);

    logic [SAMPLE_WIDTH-1:0] r_sample  [QUEUE_DEPTH];
    logic                    r_restart [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr;
    logic [QUEUE_AW-1:0]     r_rd_ptr;
    logic [QUEUE_AW:0]       r_fill;
    logic                    push_ok;
    logic                    pop_ok;

    assign full    = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = i_q_pop && (r_fill != '0);

    assign o_stat.not_empty = (r_fill != '0);
    assign o_stat.restart   = r_restart[r_rd_ptr];
    assign o_sample         = $signed(r_sample[r_rd_ptr]);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_sample[r_wr_ptr]  <= i_sample;
            r_restart[r_wr_ptr] <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_back
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [CFG_W-1:0]               i_window_size,
    input  wire t_front_stat                    i_stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                                o_q_pop,
    input  wire logic                           pop,
    output logic                                empty,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_max
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int DW = POS_W + SAMPLE_WIDTH;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_count, n_count;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [CW-1:0]           r_seen, n_seen;
    logic [SAMPLE_WIDTH-1:0] r_front_val, n_front_val;
    logic [POS_W-1:0]        r_front_pos, n_front_pos;
    logic [SAMPLE_WIDTH-1:0] r_v, n_v;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_data, n_out_data;

    logic [CW-1:0]           w;
    logic [POS_W-1:0]        age;
    logic                    expired;
    logic                    back_drop;
    logic [CW-1:0]           seen_inc;
    logic                    produce;
    logic                    append_stall;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DW-1:0]           ram_rdata;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                              input logic [CW-1:0] offset);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(offset);
        if (s >= (CW+1)'(MAX_WINDOW)) begin
            s = s - (CW+1)'(MAX_WINDOW);
        end
        return AW'(s);
    endfunction

    always_comb begin
        if (i_window_size == '0) begin
            w = CW'(1);
        end else if (32'(i_window_size) > 32'(MAX_WINDOW)) begin
            w = CW'(MAX_WINDOW);
        end else begin
            w = CW'(i_window_size);
        end
    end

    assign age          = r_pos - r_front_pos;
    assign expired      = (r_count != '0) && (32'(age) >= 32'(w));
    assign back_drop    = $signed(ram_rdata[SAMPLE_WIDTH-1:0]) <= $signed(r_v);
    assign seen_inc     = (r_seen < w) ? r_seen + 1'b1 : r_seen;
    assign produce      = (seen_inc >= w);
    assign append_stall = produce && r_out_valid && !pop;

    assign empty        = !r_out_valid;
    assign o_window_max = $signed(r_out_data);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.not_empty) begin
                    n_state = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                if (expired && (r_count != CW'(1))) begin
                    n_state = ST_FRONT_WAIT;
                end else if (!expired) begin
                    n_state = ST_EVICT;
                end else begin
                    n_state = ST_EVICT;
                end
            end
            ST_FRONT_WAIT: n_state = ST_EXPIRE;
            ST_EVICT: begin
                n_state = (r_count == '0) ? ST_APPEND : ST_BACK_WAIT;
            end
            ST_BACK_WAIT: begin
                n_state = back_drop ? ST_EVICT : ST_APPEND;
            end
            ST_APPEND: begin
                if (!append_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_front_val = r_front_val;
        n_front_pos = r_front_pos;
        n_v         = r_v;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !pop;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = f_slot(r_head, r_count);
        ram_wdata   = {r_pos, r_v};
        ram_raddr   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.not_empty) begin
                    o_q_pop = 1'b1;
                    n_v     = i_sample;
                    if (i_stat.restart) begin
                        n_head  = '0;
                        n_count = '0;
                        n_pos   = '0;
                        n_seen  = '0;
                    end else if (r_seen > w) begin
                        n_seen = w;
                    end
                end
            end
            ST_EXPIRE: begin
                ram_raddr = f_slot(r_head, CW'(1));
                if (expired) begin
                    n_head  = f_slot(r_head, CW'(1));
                    n_count = r_count - 1'b1;
                end
            end
            ST_FRONT_WAIT: begin
                n_front_val = ram_rdata[SAMPLE_WIDTH-1:0];
                n_front_pos = ram_rdata[DW-1:SAMPLE_WIDTH];
            end
            ST_EVICT: begin
                ram_raddr = f_slot(r_head, r_count - 1'b1);
            end
            ST_BACK_WAIT: begin
                if (back_drop) begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_APPEND: begin
                if (!append_stall) begin
                    if (32'(r_count) < 32'(MAX_WINDOW)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_count == '0) begin
                            n_front_val = r_v;
                            n_front_pos = r_pos;
                        end
                    end
                    n_pos  = r_pos + 1'b1;
                    n_seen = seen_inc;
                    if (produce) begin
                        n_out_valid = 1'b1;
                        n_out_data  = (r_count == '0) ? r_v : r_front_val;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    swm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_deque (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_front_pos <= n_front_pos;
        r_v         <= n_v;
        r_out_data  <= n_out_data;
    end

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result changed before transfer");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_stat.not_empty && i_stat.restart)
        |=> (r_count == '0 && r_pos == '0 && r_seen == '0))
        else $error("restart did not clear the deque");

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT) |-> (32'(r_count) < 32'(w)))
        else $error("deque holds an expired entry after expiry pass");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_APPEND && 32'(r_count) < 32'(MAX_WINDOW)))
        else $error("deque write without room");

endmodule

`default_nettype wire

// ===== verif/sliding_window_max_test.sv =====
`timescale 1ns / 1ps

module sliding_window_max_test
    import swm_pkg::*;
();

    localparam int MAX_WIN       = 64;
    localparam int SAMPLE_W      = 32;
    localparam int SETTLE_CYCLES = 1000;   // 4 queued samples plus one in flight, full deque
    localparam int DRAIN_LIMIT   = 50000;
    localparam int PRINT_LIMIT   = 40;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 93;

    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        RUN_NOISE,
        RUN_NEAR_ZERO,
        RUN_RISING,
        RUN_FALLING,
        RUN_EXTREME
    } t_run;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_restart;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] o_window_max;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_W-1:0]           i_cfg_window_size;

    sliding_window_max #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_sample          (i_sample),
        .i_restart         (i_restart),
        .empty             (empty),
        .pop               (pop),
        .o_window_max      (o_window_max),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size)
    );

    // Deque predictor state
    logic [CFG_W-1:0]           win_reg;
    logic signed [SAMPLE_W-1:0] dq_val [MAX_WIN];
    logic [POS_W-1:0]           dq_pos [MAX_WIN];
    int unsigned                dq_head;
    int unsigned                dq_count;
    logic [POS_W-1:0]           next_pos;
    int unsigned                seq_len;
    logic signed [SAMPLE_W-1:0] expected_max [$];

    // Stimulus state
    bit                         no_idle;
    t_run                       run_style;
    int                         run_left;
    logic signed [SAMPLE_W-1:0] run_level;

    int fail_count;
    int samples_sent;
    int restarts_sent;
    int maxima_checked;
    int settings_written;
    logic signed [SAMPLE_W-1:0] want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("%0t: run timed out", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        if (run_left == 0) begin
            run_left  = $urandom_range(1, 24);
            run_style = t_run'($urandom_range(0, 4));
            run_level = $urandom;
        end
        run_left--;
        case (run_style)
            RUN_NOISE: begin
                run_level = $urandom;
            end
            RUN_NEAR_ZERO: begin
                run_level = $signed($urandom_range(0, 8)) - 4;
            end
            RUN_RISING: begin
                run_level = run_level + $urandom_range(0, 3);
            end
            RUN_FALLING: begin
                run_level = run_level - $urandom_range(0, 3);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: run_level = SMP_MIN;
                    1: run_level = SMP_MAX;
                    2: run_level = '0;
                    default: run_level = '1;
                endcase
            end
        endcase
        return run_level;
    endfunction

    function automatic void predict_window_max(input logic signed [SAMPLE_W-1:0] v,
                                               input logic r);
        int unsigned w;
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
        if (r) begin
            dq_head  = 0;
            dq_count = 0;
            next_pos = '0;
            seq_len  = 0;
        end
        if (seq_len > w) begin
            seq_len = w;
        end
        while (dq_count > 0 && 16'(next_pos - dq_pos[dq_head]) >= w) begin
            dq_head = (dq_head + 1) % MAX_WIN;
            dq_count--;
        end
        while (dq_count > 0 && dq_val[(dq_head + dq_count - 1) % MAX_WIN] <= v) begin
            dq_count--;
        end
        if (dq_count < MAX_WIN) begin
            dq_val[(dq_head + dq_count) % MAX_WIN] = v;
            dq_pos[(dq_head + dq_count) % MAX_WIN] = next_pos;
            dq_count++;
        end
        next_pos++;
        if (seq_len < w) begin
            seq_len++;
        end
        if (seq_len >= w) begin
            expected_max.insert(expected_max.size(), dq_val[dq_head]);
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_sample  <= v;
        i_restart <= r;
        do @(posedge i_clk); while (full);
        predict_window_max(v, r);
        samples_sent++;
        if (r) begin
            restarts_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_reg = v;
        settings_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop pushing, let every expected maximum drain, then let the block go quiet.
    task automatic settle_block();
        int n;
        push <= 1'b0;
        n = 0;
        while (expected_max.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        if (expected_max.size() != 0) begin
            $display("%0t: %0d expected window maxima never arrived, next expected %0d",
                     $time, expected_max.size(), expected_max[0]);
            fail_count++;
            expected_max.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            maxima_checked++;
            if (expected_max.size() == 0) begin
                fail_count++;
                if (fail_count <= PRINT_LIMIT) begin
                    $display("%0t: window max transfer with none expected, expected none, got %0d",
                             $time, o_window_max);
                end
            end else begin
                want = expected_max[0];
                expected_max.delete(0);
                if (o_window_max !== want) begin
                    fail_count++;
                    if (fail_count <= PRINT_LIMIT) begin
                        $display("%0t: window max mismatch, expected %0d, got %0d",
                                 $time, want, o_window_max);
                    end
                end
            end
        end
    end

    initial begin : result_drain
        int gap;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Reset window is 1: every sample is its own maximum.
    task automatic test_reset_window();
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(32'sd1, 1'b0);
        settle_block();
    endtask

    // Equal samples evict each other from the back.
    task automatic test_equal_values();
        write_window(CFG_W'(3));
        send_sample(32'sd5, 1'b1);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd3, 1'b0);
        settle_block();
    endtask

    task automatic test_window_zero();
        write_window('0);
        send_sample(32'sd4, 1'b0);
        send_sample(-32'sd9, 1'b0);
        send_sample(-32'sd9, 1'b0);
        settle_block();
    endtask

    // Window starts not yet full and fills, then is shrunk mid-sequence without a restart.
    task automatic test_resize_mid_sequence();
        write_window(CFG_W'(4));
        send_sample(32'sd10, 1'b1);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd2, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd0, 1'b0);
        settle_block();
        write_window(CFG_W'(2));
        send_sample(32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd8, 1'b0);
        settle_block();
    endtask

    task automatic test_random_phases();
        int unsigned w;
        int          odds;
        logic        r;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: w = 127;
                1: w = MAX_WIN;
                2: w = 1;
                3: w = 65;
                4: w = 0;
                5: w = 2;
                6: w = $urandom_range(3, 12);
                7: w = $urandom_range(13, 63);
                8: w = 8;
                default: w = 32;
            endcase
            write_window(CFG_W'(w));
            no_idle = (p == 3 || p == 7);
            odds    = (w >= 32) ? 150 : 30;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 0) begin
                    r = $urandom_range(0, 1);
                end else begin
                    r = ($urandom_range(1, odds) == 1);
                end
                send_sample(draw_sample(), r);
            end
            no_idle = 1'b0;
            settle_block();
        end
    endtask

    initial begin
        push              = 1'b0;
        i_sample          = '0;
        i_restart         = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_window_size = '0;
        i_rst_n           = 1'b0;
        win_reg           = CFG_W'(1);
        dq_head           = 0;
        dq_count          = 0;
        next_pos          = '0;
        seq_len           = 0;
        no_idle           = 1'b0;
        run_left          = 0;
        run_style         = RUN_NOISE;
        run_level         = '0;
        fail_count        = 0;
        samples_sent      = 0;
        restarts_sent     = 0;
        maxima_checked    = 0;
        settings_written  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_window();
        test_equal_values();
        test_window_zero();
        test_resize_mid_sequence();
        test_random_phases();

        $display("Sent %0d samples with %0d restarts over %0d window writes",
                 samples_sent, restarts_sent, settings_written);
        $display("Checked %0d window maxima transfers", maxima_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_front.sv
rtl/swm_back.sv
rtl/sliding_window_max.sv
verif/sliding_window_max_test.sv
